>>> rtl/gfc_pkg.sv
// ----------------------------------------------------------------------------
// gfc_pkg
// Shared types and constants of the gated frequency counter: controller
// states, controller/datapath command and status groups, seven-segment table.
// ----------------------------------------------------------------------------
package gfc_pkg;

    localparam int GATE_W  = 24;
    localparam int FREQ_W  = 20;
    localparam int POS_W   = 3;
    localparam int DIGIT_W = 4;
    localparam int SEG_W   = 7;

    localparam logic [GATE_W-1:0] GATE_RESET = 24'd1000000;
    localparam logic [FREQ_W-1:0] FREQ_MAX   = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_SHOW
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic count;      // take a tick into the counters
        logic mul;        // form edges * ticks-per-second
        logic load;       // seed divider and digit registers
        logic div_step;   // one quotient bit, one BCD shift
        logic shift_out;  // advance to the next digit
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic gate_done;  // this tick closes the gate
        logic div_last;   // final quotient bit this cycle
        logic pos_last;   // least significant digit on show
    } sts_t;

    // Active-low pattern, bit0 = g ... bit6 = a; blank for non-decimal codes.
    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 7'b0000001;
            4'd1:    s = 7'b1001111;
            4'd2:    s = 7'b0010010;
            4'd3:    s = 7'b0000110;
            4'd4:    s = 7'b1001100;
            4'd5:    s = 7'b0100100;
            4'd6:    s = 7'b0100000;
            4'd7:    s = 7'b0001111;
            4'd8:    s = 7'b0000000;
            4'd9:    s = 7'b0000100;
            default: s = 7'b1111111;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/gfc_ctrl.sv
// ----------------------------------------------------------------------------
// gfc_ctrl
// Controller: sequences count, multiply, divide and digit readout.
// ----------------------------------------------------------------------------
module gfc_ctrl
    import gfc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    output logic   out_valid,
    input  logic   out_ready,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && sts.gate_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_SHOW;
                end
            end
            ST_SHOW:
            begin
                if (out_ready && sts.pos_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.count = in_valid;
            end
            ST_MUL:  cmd.mul      = 1'b1;
            ST_LOAD: cmd.load     = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_SHOW:
            begin
                out_valid     = 1'b1;
                cmd.shift_out = out_ready;
            end
            default: cmd = '0;
        endcase
    end

endmodule

>>> rtl/gfc_dp.sv
// ----------------------------------------------------------------------------
// gfc_dp
// Datapath: edge/tick counters, gate register, constant multiplier,
// restoring divider feeding a double-dabble BCD converter, digit readout.
// ----------------------------------------------------------------------------
module gfc_dp
    import gfc_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 1000000,
    parameter int NUM_DIGITS       = 6,
    parameter int COUNT_BITS       = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [GATE_W-1:0]   cfg_data,
    input  logic                pulse_edge,
    input  cmd_t                cmd,
    output sts_t                sts,
    output logic [POS_W-1:0]    digit_position,
    output logic [DIGIT_W-1:0]  digit_value,
    output logic [SEG_W-1:0]    segments,
    output logic [FREQ_W-1:0]   frequency_hz,
    output logic                last
);

    localparam int CB    = COUNT_BITS;
    localparam int Q     = $clog2(TICKS_PER_SECOND + 1);   // quotient never exceeds TPS
    localparam int PW    = CB + Q;
    localparam int SW    = $clog2(Q);
    localparam int BCD_W = NUM_DIGITS * DIGIT_W;
    localparam int WIDE  = (CB > GATE_W) ? CB : GATE_W;
    localparam int QW    = (Q > FREQ_W) ? Q : FREQ_W;

    localparam logic [CB-1:0]   CMAX      = '1;
    localparam logic [WIDE-1:0] CMAX_WIDE = WIDE'(CMAX);
    localparam logic [Q-1:0]    TPS       = Q'(TICKS_PER_SECOND);

    // add 3 to each digit of 5 or more, then shift in one binary bit
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] v, input logic b);
        logic [BCD_W-1:0] t;
        t = v;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (t[i*DIGIT_W +: DIGIT_W] >= 4'd5)
            begin
                t[i*DIGIT_W +: DIGIT_W] = t[i*DIGIT_W +: DIGIT_W] + 4'd3;
            end
        end
        return {t[BCD_W-2:0], b};
    endfunction

    logic [GATE_W-1:0] gate_reg,  gate_next;
    logic [CB-1:0]     edge_reg,  edge_next;
    logic [CB-1:0]     tick_reg,  tick_next;
    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [SW-1:0]     step_reg,  step_next;
    logic [CB-1:0]     ecap_reg,  ecap_next;
    logic [CB-1:0]     dsr_reg,   dsr_next;
    logic [PW-1:0]     prod_reg,  prod_next;
    logic [CB-1:0]     rem_reg,   rem_next;
    logic [Q-1:0]      num_reg,   num_next;
    logic [Q-1:0]      quo_reg,   quo_next;
    logic [BCD_W-1:0]  bcd_reg,   bcd_next;

    logic [WIDE-1:0]   gate_wide;
    logic [CB-1:0]     gate_eff;
    logic              edge_inc;
    logic [CB-1:0]     edge_new;
    logic [CB-1:0]     tick_new;
    logic [CB:0]       rem_sh;
    logic              q_bit;
    logic [QW-1:0]     quo_wide;

    // zero acts as one; clamp to what the tick counter can hold
    always_comb
    begin
        gate_wide = WIDE'(gate_reg);
        if (gate_wide == '0)
        begin
            gate_wide = WIDE'(1);
        end
        if (gate_wide > CMAX_WIDE)
        begin
            gate_wide = CMAX_WIDE;
        end
        gate_eff = gate_wide[CB-1:0];
    end

    assign edge_inc = pulse_edge && (edge_reg != CMAX);
    assign edge_new = edge_inc ? edge_reg + CB'(1) : edge_reg;
    assign tick_new = (tick_reg != CMAX) ? tick_reg + CB'(1) : tick_reg;

    assign rem_sh = {rem_reg, num_reg[Q-1]};
    assign q_bit  = (rem_sh >= {1'b0, dsr_reg});

    always_comb
    begin
        gate_next = cfg_we ? cfg_data : gate_reg;
        edge_next = edge_reg;
        tick_next = tick_reg;
        pos_next  = pos_reg;
        step_next = step_reg;
        ecap_next = ecap_reg;
        dsr_next  = dsr_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        bcd_next  = bcd_reg;

        if (cmd.count)
        begin
            if (sts.gate_done)
            begin
                ecap_next = edge_new;
                dsr_next  = tick_new;
                edge_next = '0;
                tick_next = '0;
            end
            else
            begin
                edge_next = edge_new;
                tick_next = tick_new;
            end
        end

        if (cmd.mul)
        begin
            prod_next = PW'(ecap_reg) * PW'(TPS);
        end

        if (cmd.load)
        begin
            rem_next  = prod_reg[PW-1:Q];
            num_next  = prod_reg[Q-1:0];
            quo_next  = '0;
            bcd_next  = '0;
            step_next = '0;
            pos_next  = '0;
        end

        if (cmd.div_step)
        begin
            rem_next  = q_bit ? CB'(rem_sh - {1'b0, dsr_reg}) : rem_sh[CB-1:0];
            num_next  = num_reg << 1;
            quo_next  = {quo_reg[Q-2:0], q_bit};
            bcd_next  = dabble(bcd_reg, q_bit);
            step_next = step_reg + SW'(1);
        end

        if (cmd.shift_out)
        begin
            bcd_next = bcd_reg << DIGIT_W;
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg <= GATE_RESET;
            edge_reg <= '0;
            tick_reg <= '0;
            pos_reg  <= '0;
            step_reg <= '0;
        end
        else
        begin
            gate_reg <= gate_next;
            edge_reg <= edge_next;
            tick_reg <= tick_next;
            pos_reg  <= pos_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ecap_reg <= ecap_next;
        dsr_reg  <= dsr_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        bcd_reg  <= bcd_next;
    end

    assign sts.gate_done = (tick_new >= gate_eff);
    assign sts.div_last  = (step_reg == SW'(Q - 1));
    assign sts.pos_last  = (pos_reg == POS_W'(NUM_DIGITS - 1));

    assign quo_wide       = QW'(quo_reg);
    assign frequency_hz   = (quo_wide > QW'(FREQ_MAX)) ? FREQ_MAX : quo_wide[FREQ_W-1:0];
    assign digit_position = pos_reg;
    assign digit_value    = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign segments       = seg_of(digit_value);
    assign last           = sts.pos_last;

endmodule

>>> rtl/gated_frequency_counter_7seg_top.sv
// ----------------------------------------------------------------------------
// gated_frequency_counter_7seg_top
// Gated frequency counter: counts flagged timebase ticks over a programmable
// gate, then reads out edges * TICKS_PER_SECOND / ticks as decimal digits
// with seven-segment patterns, most significant digit first.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                    | transaction
//  ---------+--------------------------------------------+-------------------------
//  in       | in_valid, in_ready, pulse_edge             | one timebase tick
//  out      | out_valid, out_ready, digit_position,      | one digit of the reading
//           | digit_value, segments, frequency_hz, last  |
//  cfg      | cfg_we, cfg_data                           | gate length write
//
//  Sequence: a tick that leaves the gate open only advances the counters. The
//  tick that closes it is followed by a multiply, a divider load and Q divide
//  steps, Q = clog2(TICKS_PER_SECOND + 1) (20 by default), then NUM_DIGITS
//  output transactions. The restoring divider, one quotient bit per cycle,
//  feeds the BCD converter.
//  Reset: counters clear, gate length returns to 1000000.
//  Stalls: with out_ready low the current digit holds; no tick is taken
//  from closing the gate until the last digit is delivered.
//
module gated_frequency_counter_7seg_top
    import gfc_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 1000000,
    parameter int NUM_DIGITS       = 6,
    parameter int COUNT_BITS       = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [GATE_W-1:0]   cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                pulse_edge,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [POS_W-1:0]    digit_position,
    output logic [DIGIT_W-1:0]  digit_value,
    output logic [SEG_W-1:0]    segments,
    output logic [FREQ_W-1:0]   frequency_hz,
    output logic                last
);

    cmd_t cmd;
    sts_t sts;

    // sequencing: idle/count -> multiply -> load -> divide -> show digits
    gfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // counters, arithmetic and digit registers
    gfc_dp #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .NUM_DIGITS       (NUM_DIGITS),
        .COUNT_BITS       (COUNT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .pulse_edge     (pulse_edge),
        .cmd            (cmd),
        .sts            (sts),
        .digit_position (digit_position),
        .digit_value    (digit_value),
        .segments       (segments),
        .frequency_hz   (frequency_hz),
        .last           (last)
    );

    // never take a tick while a reading is on show
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output both open");

    // BCD conversion must leave decimal digits only
    a_digit_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_value <= 4'd9))
        else $error("non-decimal digit");

    // digits advance by one within a reading
    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=>
            (out_valid && (digit_position == POS_W'($past(digit_position) + 3'd1))))
        else $error("digit position skipped");

    // one frequency for every digit of a reading
    a_freq_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> $stable(frequency_hz))
        else $error("frequency changed within a reading");

    // after the last digit the block returns to counting
    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> (in_ready && !out_valid))
        else $error("no return to counting");

endmodule

>>> tb/gated_frequency_counter_7seg_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gated_frequency_counter_7seg_top_test
// Streams timebase ticks with random edge flags into the gated frequency
// counter under several gate lengths, predicts each six-digit reading and
// checks every digit transaction field by field against that prediction.
// ----------------------------------------------------------------------------
module gated_frequency_counter_7seg_top_test;
    import gfc_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_TICKS  = 115;
    localparam int SETTLE_CYCLES = 48;     // closing tick plus six digits, with margin
    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int MAX_GAP       = 16;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIGITS        = 6;
    localparam longint unsigned TICKS_PER_SEC = 1000000;
    localparam longint unsigned COUNT_MAX     = (64'd1 << 24) - 1;

    // One digit transaction, in port order.
    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [DIGIT_W-1:0] value;
        logic [SEG_W-1:0]   pattern;
        logic [FREQ_W-1:0]  freq;
        logic               last_digit;
    } readout_t;

    // Tracks the edge and tick counters, and holds the digits still owed.
    class readout_scoreboard;
        logic [GATE_W-1:0] gate_len;
        longint unsigned   edges;
        longint unsigned   ticks;
        readout_t          expected_q[$];
        logic [SEG_W-1:0]  seg_rom [10];
        int                mismatches;
        int                digits_checked;
        int                gates_closed;
        int                ticks_taken;

        function new();
            seg_rom[0] = 7'b0000001;
            seg_rom[1] = 7'b1001111;
            seg_rom[2] = 7'b0010010;
            seg_rom[3] = 7'b0000110;
            seg_rom[4] = 7'b1001100;
            seg_rom[5] = 7'b0100100;
            seg_rom[6] = 7'b0100000;
            seg_rom[7] = 7'b0001111;
            seg_rom[8] = 7'b0000000;
            seg_rom[9] = 7'b0000100;
            gate_len       = GATE_RESET;
            edges          = 0;
            ticks          = 0;
            mismatches     = 0;
            digits_checked = 0;
            gates_closed   = 0;
            ticks_taken    = 0;
        endfunction

        function void set_gate(logic [GATE_W-1:0] value);
            gate_len = value;
        endfunction

        // Count one tick; when it closes the gate, queue the six digits.
        function void note_tick(logic edge_seen);
            longint unsigned limit;
            longint unsigned freq;
            longint unsigned scale;
            readout_t        r;
            limit = (gate_len == 0) ? 1 : gate_len;
            ticks_taken++;
            if (edge_seen && edges < COUNT_MAX)
                edges++;
            if (ticks < COUNT_MAX)
                ticks++;
            if (ticks < limit)
                return;
            freq  = edges * TICKS_PER_SEC / ticks;
            scale = 100000;
            for (int i = 0; i < DIGITS; i++)
            begin
                r.position = POS_W'(i);
                r.value    = DIGIT_W'((freq / scale) % 10);
                r.pattern  = seg_rom[r.value];
                if (freq > FREQ_MAX)
                    r.freq = FREQ_MAX;
                else
                    r.freq = freq[FREQ_W-1:0];
                r.last_digit = (i == DIGITS - 1);
                expected_q.push_back(r);
                scale = scale / 10;
            end
            gates_closed++;
            edges = 0;
            ticks = 0;
        endfunction

        function void check_digit(readout_t got);
            readout_t want;
            bit       bad;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: unexpected digit pos=%0d value=%0d seg=%b freq=%0d last=%0d",
                             got.position, got.value, got.pattern, got.freq, got.last_digit);
                return;
            end
            want = expected_q.pop_front();
            digits_checked++;
            bad = (got.position !== want.position) || (got.value !== want.value) ||
                  (got.pattern !== want.pattern) || (got.freq !== want.freq) ||
                  (got.last_digit !== want.last_digit);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("ERROR: digit expected pos=%0d value=%0d seg=%b freq=%0d last=%0d",
                             want.position, want.value, want.pattern, want.freq,
                             want.last_digit);
                    $display("       digit actual   pos=%0d value=%0d seg=%b freq=%0d last=%0d",
                             got.position, got.value, got.pattern, got.freq, got.last_digit);
                end
            end
        endfunction
    endclass

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               cfg_we     = 1'b0;
    logic [GATE_W-1:0]  cfg_data   = '0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic               pulse_edge = 1'b0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [POS_W-1:0]   digit_position;
    logic [DIGIT_W-1:0] digit_value;
    logic [SEG_W-1:0]   segments;
    logic [FREQ_W-1:0]  frequency_hz;
    logic               last;

    readout_scoreboard sb;
    bit tx_burst     = 1'b0;   // sender offers back to back
    bit tx_hurry     = 1'b0;   // force back to back while the output is held
    bit rx_burst     = 1'b0;   // receiver takes back to back
    bit hold_request = 1'b0;   // ask the receiver for one long hold-off
    int rx_wait      = 0;
    int idle_cycles  = 0;
    int settings_used = 0;

    gated_frequency_counter_7seg_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pulse_edge     (pulse_edge),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digit_position (digit_position),
        .digit_value    (digit_value),
        .segments       (segments),
        .frequency_hz   (frequency_hz),
        .last           (last)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Receiver: check each accepted digit, then draw how long to stall before
    // the next one. A pending hold request overrides the draw with a long stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                sb.check_digit({digit_position, digit_value, segments, frequency_hz, last});
                if ($urandom_range(0, 15) == 0)
                    rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            else if (rx_wait > 0)
                rx_wait--;
            if (hold_request)
            begin
                rx_wait      = LONG_HOLD;
                hold_request = 1'b0;
            end
        end
    end

    // Drive ready away from the sampling edge.
    always @(negedge clk)
        out_ready <= rst_n && (rx_wait == 0);

    // Watchdog: end the run if no transaction moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one tick after a random gap; hold valid and the flag until accepted.
    // Leave valid high so a zero gap on the next tick keeps the stream dense.
    task automatic send_tick(input logic edge_seen);
        int gap;
        if ($urandom_range(0, 15) == 0)
            tx_burst = !tx_burst;
        gap = (tx_burst || tx_hurry) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        pulse_edge <= edge_seen;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_tick(edge_seen);
        @(negedge clk);
    endtask

    task automatic send_ticks(input int count, input int density_pct);
        repeat (count)
            send_tick($urandom_range(0, 99) < density_pct);
    endtask

    // Drop valid, wait for every owed digit, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the gate length only while the block is idle.
    task automatic program_gate(input logic [GATE_W-1:0] value);
        drain();
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.set_gate(value);
        settings_used++;
    endtask

    initial
    begin
        int                random_sent;
        int                count;
        int                density;
        logic [GATE_W-1:0] gate;

        sb = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Under the reset gate of one million ticks these only accumulate.
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);

        // A gate of zero acts as one: the first tick closes over the carried
        // counts, then an empty tick reads zero and a full tick reads 1 MHz.
        program_gate('0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);

        program_gate(GATE_W'(3));
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);

        // Full-scale gate: accumulate quietly, then shorten it to close.
        program_gate('1);
        repeat (6) send_tick(1'b0);
        send_tick(1'b1);
        program_gate(GATE_W'(11));
        repeat (4) send_tick(1'b0);

        // Back-pressure: every tick closes the gate while the receiver holds
        // off, so the block fills and stalls its input.
        program_gate(GATE_W'(1));
        hold_request = 1'b1;
        tx_hurry     = 1'b1;
        send_ticks(12, 50);
        tx_hurry     = 1'b0;

        // Random phases: mostly short gates, some zero, some long enough to
        // carry counts into the next phase.
        random_sent = 0;
        while (random_sent < RANDOM_TICKS)
        begin
            case ($urandom_range(0, 9))
                0:       gate = '0;
                1:       gate = GATE_W'($urandom_range(1000, 24'hFFFFFF));
                default: gate = GATE_W'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 3))
                0:       density = 0;
                1:       density = 100;
                default: density = $urandom_range(1, 99);
            endcase
            count = $urandom_range(3, 20);
            program_gate(gate);
            send_ticks(count, density);
            random_sent += count;
        end

        drain();
        $display("Run: %0d ticks over %0d gate settings, %0d gates closed, %0d digits checked",
                 sb.ticks_taken, settings_used, sb.gates_closed, sb.digits_checked);
        $display("Covered zero, full-scale and reset gates plus a %0d-cycle output hold; %0d bad",
                 LONG_HOLD, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
rtl/gfc_pkg.sv
rtl/gfc_ctrl.sv
rtl/gfc_dp.sv
rtl/gated_frequency_counter_7seg_top.sv
tb/gated_frequency_counter_7seg_top_test.sv
